// ===== design/bitplane_tile_blitter_assert.svh =====
// ----------------------------------------------------------------------------
// Bitplane tile blitter assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef BITPLANE_TILE_BLITTER_ASSERT_SVH
`define BITPLANE_TILE_BLITTER_ASSERT_SVH

// Checked only outside reset.
`define BTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BTB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/btb_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitplane tile blitter package
// Payload types, register codes and the fixed blending table.
// ----------------------------------------------------------------------------
package btb_pkg;

  localparam int TILE_PIXELS = 8;
  localparam int TILE_BITS   = 3;
  localparam int COLOR_W     = 12;

  typedef enum logic [2:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_WIDTH_TILES  = 3'd2,
    REG_HEIGHT_TILES = 3'd3,
    REG_BLEND_MODE   = 3'd4,
    REG_TWO_BPP      = 3'd5,
    REG_PALETTE      = 3'd6
  } reg_index_t;

  // Transparent blending modes
  localparam logic [3:0] MODE_CLEAR_A = 4'h0;
  localparam logic [3:0] MODE_CLEAR_B = 4'h5;
  localparam logic [3:0] MODE_CLEAR_C = 4'ha;
  localparam logic [3:0] MODE_CLEAR_D = 4'hf;

  typedef struct packed {
    logic [7:0] plane_low;
    logic [7:0] plane_high;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        pixel_x;
    logic [15:0]        pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_of_line;
  } out_item_t;

  // One tile line after the lanes: draw mask, colour per pixel, position.
  typedef struct packed {
    logic [TILE_PIXELS-1:0]              draw;
    logic [TILE_PIXELS-1:0][COLOR_W-1:0] color;
    logic [15:0]                         x_base;
    logic [15:0]                         y;
  } line_t;

  localparam logic [1:0] BLEND_TABLE [16][4] = '{
    '{2'd0, 2'd0, 2'd1, 2'd2}, '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd3, 2'd1}, '{2'd0, 2'd3, 2'd1, 2'd2},
    '{2'd1, 2'd0, 2'd1, 2'd2}, '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd2, 2'd3, 2'd1}, '{2'd1, 2'd3, 2'd1, 2'd2},
    '{2'd2, 2'd0, 2'd1, 2'd2}, '{2'd2, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd3, 2'd1}, '{2'd2, 2'd3, 2'd1, 2'd2},
    '{2'd3, 2'd0, 2'd1, 2'd2}, '{2'd3, 2'd1, 2'd2, 2'd3},
    '{2'd3, 2'd2, 2'd3, 2'd1}, '{2'd0, 2'd3, 2'd1, 2'd2}
  };

  function automatic logic mode_clears(input logic [3:0] mode);
    return (mode == MODE_CLEAR_A) || (mode == MODE_CLEAR_B) ||
           (mode == MODE_CLEAR_C) || (mode == MODE_CLEAR_D);
  endfunction

endpackage

// ===== design/btb_lane.sv =====
// ----------------------------------------------------------------------------
// Bitplane tile blitter pixel lane
// Colour index, transparency, blending and palette lookup for one pixel.
// ----------------------------------------------------------------------------
module btb_lane (
  input  logic                       bit_lo,
  input  logic                       bit_hi,
  input  logic [3:0]                 blend_mode,
  input  logic                       two_bpp,
  input  logic [4*btb_pkg::COLOR_W-1:0] palette,
  output logic                       draw,
  output logic [btb_pkg::COLOR_W-1:0] color
);
  import btb_pkg::*;

  logic [1:0] idx;
  logic [1:0] blended;

  assign idx     = {two_bpp & bit_hi, bit_lo};
  assign blended = BLEND_TABLE[blend_mode][idx];
  assign draw    = !(mode_clears(blend_mode) && (idx == 2'd0));

  always_comb begin
    case (blended)
      2'd0:    color = palette[0*COLOR_W +: COLOR_W];
      2'd1:    color = palette[1*COLOR_W +: COLOR_W];
      2'd2:    color = palette[2*COLOR_W +: COLOR_W];
      2'd3:    color = palette[3*COLOR_W +: COLOR_W];
      default: color = palette[0*COLOR_W +: COLOR_W];
    endcase
  end

endmodule

// ===== design/btb_merge.sv =====
// ----------------------------------------------------------------------------
// Bitplane tile blitter merge stage
// Holds one tile line from the lanes and issues its drawn pixels in order.
// ----------------------------------------------------------------------------
`include "bitplane_tile_blitter_assert.svh"

module btb_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               line_load,
  input  btb_pkg::line_t     line_in,
  output logic               line_free,
  output logic               out_valid,
  input  logic               out_stall,
  output btb_pkg::out_item_t out_data
);
  import btb_pkg::*;

  logic [TILE_PIXELS-1:0]              mask_r, mask_nxt;
  logic [TILE_PIXELS-1:0][COLOR_W-1:0] color_r;
  logic [15:0]                         x_base_r;
  logic [15:0]                         y_r;
  logic                                o_valid_r, o_valid_nxt;
  out_item_t                           o_data_r;

  logic                   advance;
  logic                   pop;
  logic [TILE_PIXELS-1:0] rest;
  logic [TILE_PIXELS-1:0] pick;
  logic [TILE_BITS-1:0]   pick_idx;

  assign advance   = !o_valid_r || !out_stall;
  assign pop       = (|mask_r) && advance;
  assign rest      = mask_r & (mask_r - TILE_PIXELS'(1));
  assign pick      = mask_r & ~rest;
  assign line_free = !(|mask_r) || (pop && (rest == '0));

  // leftmost remaining pixel (lowest mask bit)
  always_comb begin
    pick_idx = '0;
    for (int s = 0; s < TILE_PIXELS; s++) begin
      if (pick[s]) pick_idx = pick_idx | TILE_BITS'(s);
    end
  end

  always_comb begin
    if (line_load) mask_nxt = line_in.draw;
    else if (pop)  mask_nxt = rest;
    else           mask_nxt = mask_r;
  end

  always_comb begin
    if (pop)          o_valid_nxt = 1'b1;
    else if (advance) o_valid_nxt = 1'b0;
    else              o_valid_nxt = o_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= '0;
      o_valid_r <= 1'b0;
    end else begin
      mask_r    <= mask_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (line_load) begin
      color_r  <= line_in.color;
      x_base_r <= line_in.x_base;
      y_r      <= line_in.y;
    end
    if (pop) begin
      o_data_r.pixel_x      <= x_base_r + {13'd0, pick_idx};
      o_data_r.pixel_y      <= y_r;
      o_data_r.pixel_color  <= color_r[pick_idx];
      o_data_r.last_of_line <= (rest == '0);
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

  `BTB_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !o_valid_r && (mask_r == '0), "not idle after reset")
  `BTB_ASSERT(a_pop_one, pop && !line_load |=> $countones(mask_r) + 1 == $countones($past(mask_r)), "pop did not clear one pixel")
  `BTB_ASSERT(a_last_flag, pop |=> o_data_r.last_of_line == ($past(rest) == '0), "last flag wrong")
  `BTB_ASSERT(a_load_when_free, line_load |-> line_free, "line overwritten")

endmodule

// ===== design/bitplane_tile_blitter.sv =====
// ----------------------------------------------------------------------------
// Bitplane tile blitter
// Turns 8-pixel bitplane tile lines into palette-coloured pixel writes.
// ----------------------------------------------------------------------------
// Each input item is one tile line (low and high plane bytes), in order line,
// tile column, tile row. Eight pixel lanes decode the line in the cycle it is
// accepted; the line is held in a one-line buffer and its drawn pixels leave
// one per cycle unless the output stalls, leftmost first, via a registered
// output. An item thus gives as many pixel writes as it has drawn pixels, 0
// to 8 (8 with no transparency); a fully transparent line is still accepted
// and advances the position. The single pixel-per-cycle output port sets the
// rate. Pixels pass the line buffer, then the output register. New lines are
// accepted as the prior one issues its last pixel; lines run back to back.
// Configuration writes are always ready and take effect from the next item;
// indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module bitplane_tile_blitter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  btb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output btb_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);
  import btb_pkg::*;

  // configuration registers
  logic [15:0]          origin_x_r;
  logic [15:0]          origin_y_r;
  logic [7:0]           width_r;
  logic [7:0]           height_r;
  logic [3:0]           mode_r;
  logic                 two_bpp_r;
  logic [4*COLOR_W-1:0] palette_r;

  // position within the image
  logic [TILE_BITS-1:0] line_r, line_nxt;
  logic [7:0]           col_r, col_nxt;
  logic [7:0]           row_r, row_nxt;

  logic  in_acc;
  logic  line_free;
  logic  col_wrap, row_wrap;
  line_t line;

  assign cfg_ready = 1'b1;
  assign in_stall  = !line_free;
  assign in_acc    = in_valid && line_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      width_r    <= 8'd1;
      height_r   <= 8'd1;
      mode_r     <= 4'd1;
      two_bpp_r  <= 1'b1;
      palette_r  <= '0;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_ORIGIN_X:     origin_x_r <= cfg_data[15:0];
        REG_ORIGIN_Y:     origin_y_r <= cfg_data[15:0];
        REG_WIDTH_TILES:  width_r    <= cfg_data[7:0];
        REG_HEIGHT_TILES: height_r   <= cfg_data[7:0];
        REG_BLEND_MODE:   mode_r     <= cfg_data[3:0];
        REG_TWO_BPP:      two_bpp_r  <= cfg_data[0];
        REG_PALETTE:      palette_r  <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Counter walk: line, then column, then row; a size of 0 acts as 1.
  assign col_wrap = ({1'b0, col_r} + 9'd1) >= {1'b0, width_r};
  assign row_wrap = ({1'b0, row_r} + 9'd1) >= {1'b0, height_r};

  always_comb begin
    line_nxt = line_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (in_acc) begin
      line_nxt = line_r + TILE_BITS'(1);
      if (line_r == TILE_BITS'(TILE_PIXELS - 1)) begin
        if (col_wrap) begin
          col_nxt = '0;
          row_nxt = row_wrap ? 8'd0 : row_r + 8'd1;
        end else begin
          col_nxt = col_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= '0;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      line_r <= line_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

  // screen position of this line; wraps at 16 bits
  assign line.x_base = origin_x_r + {5'd0, col_r, TILE_BITS'(0)};
  assign line.y      = origin_y_r + {5'd0, row_r, line_r};

  // pixel lanes, lane 0 is the leftmost pixel (byte MSB)
  for (genvar s = 0; s < TILE_PIXELS; s++) begin : g_lane
    btb_lane u_lane (
      .bit_lo     (in_data.plane_low[TILE_PIXELS-1-s]),
      .bit_hi     (in_data.plane_high[TILE_PIXELS-1-s]),
      .blend_mode (mode_r),
      .two_bpp    (two_bpp_r),
      .palette    (palette_r),
      .draw       (line.draw[s]),
      .color      (line.color[s])
    );
  end

  btb_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .line_load (in_acc),
    .line_in   (line),
    .line_free (line_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
